/* design/tsa_pkg.sv */
// Package for the typed slot allocator.
// Holds the action and status codes, field widths and the request and result structs.
// It has no dependencies.
package tsa_pkg;

  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 6;
  localparam int CLASS_W  = 2;
  localparam int ZONE_W   = 4;
  localparam int STATUS_W = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD     = 3'd0,
    ACT_REMOVE  = 3'd1,
    ACT_ALLOC   = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_QUERY   = 3'd4,
    ACT_CLEAR   = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_OCCUPIED  = 3'd3,
    ST_NONE_FREE = 3'd4
  } status_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  slot_index;
    logic [CLASS_W-1:0]  slot_class;
    logic [ZONE_W-1:0]   zone_code;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [INDEX_W-1:0]  granted_slot;
    logic [ZONE_W-1:0]   zone_out;
  } rsp_t;

endpackage

/* design/tsa_req_if.sv */
// Request channel of the typed slot allocator: valid, ready and the request fields.
// Depends on tsa_pkg for the field widths.
interface tsa_req_if;
  logic                          valid;
  logic                          ready;
  logic [tsa_pkg::ACTION_W-1:0]  action;
  logic [tsa_pkg::INDEX_W-1:0]   slot_index;
  logic [tsa_pkg::CLASS_W-1:0]   slot_class;
  logic [tsa_pkg::ZONE_W-1:0]    zone_code;

  modport source (output valid, action, slot_index, slot_class, zone_code, input ready);
  modport sink (input valid, action, slot_index, slot_class, zone_code, output ready);
endinterface

/* design/tsa_rsp_if.sv */
// Result channel of the typed slot allocator: valid, ready and the result fields.
// Depends on tsa_pkg for the field widths.
interface tsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tsa_pkg::STATUS_W-1:0]  status;
  logic [tsa_pkg::INDEX_W-1:0]   granted_slot;
  logic [tsa_pkg::ZONE_W-1:0]    zone_out;

  modport source (output valid, status, granted_slot, zone_out, input ready);
  modport sink (input valid, status, granted_slot, zone_out, output ready);
endinterface

/* design/tsa_zone_ram.sv */
// Zone code memory of the typed slot allocator, one write and one registered read port.
// A read that meets a write to the same address returns the new data.
// Depends on tsa_pkg for the zone width.
module tsa_zone_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [tsa_pkg::ZONE_W-1:0]  wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [tsa_pkg::ZONE_W-1:0]  rdata
);

  logic [tsa_pkg::ZONE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

/* design/tsa_slot_table.sv */
// Slot table of the typed slot allocator: valid, occupied and class marks per slot,
// the lowest-index free-slot search, and the result for one request per commit cycle.
// Depends on tsa_pkg; drives the write port of tsa_zone_ram.
module tsa_slot_table #(
  parameter int NUM_SLOTS   = 64,
  parameter int NUM_CLASSES = 4,
  parameter int NUM_ZONES   = 16,
  parameter int AW          = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        commit,
  input  tsa_pkg::req_t               req,
  input  logic [tsa_pkg::ZONE_W-1:0]  zone_rd,
  output tsa_pkg::rsp_t               rsp,
  output logic                        zone_we,
  output logic [AW-1:0]               zone_waddr,
  output logic [tsa_pkg::ZONE_W-1:0]  zone_wdata
);

  logic [NUM_SLOTS-1:0]       valid;
  logic [NUM_SLOTS-1:0]       occupied;
  logic [NUM_SLOTS-1:0]       valid_next;
  logic [NUM_SLOTS-1:0]       occupied_next;
  logic [tsa_pkg::CLASS_W-1:0] slot_cls [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]       match;
  logic [AW-1:0]              addr;
  logic [AW-1:0]              gidx;
  logic                       found;
  logic                       in_range;
  logic                       present;
  logic                       cls_ok;
  logic                       zone_ok;
  logic                       do_add;

  assign addr     = AW'(req.slot_index);
  assign in_range = 32'(req.slot_index) < NUM_SLOTS;
  assign present  = in_range && valid[addr];
  assign cls_ok   = 32'(req.slot_class) < NUM_CLASSES;
  assign zone_ok  = 32'(req.zone_code) < NUM_ZONES;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match[i] = valid[i] && !occupied[i] && (slot_cls[i] == req.slot_class);
    end
  end

  always_comb begin
    found = 1'b0;
    gidx  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        found = 1'b1;
        gidx  = AW'(i);
      end
    end
  end

  always_comb begin
    rsp.status       = tsa_pkg::ST_OK;
    rsp.granted_slot = '0;
    rsp.zone_out     = '0;
    valid_next       = valid;
    occupied_next    = occupied;
    do_add           = 1'b0;
    case (req.action)
      tsa_pkg::ACT_ADD: begin
        if (!in_range || !cls_ok || !zone_ok) begin
          rsp.status = tsa_pkg::ST_NOT_FOUND;
        end else if (valid[addr]) begin
          rsp.status = tsa_pkg::ST_EXISTS;
        end else begin
          do_add              = 1'b1;
          valid_next[addr]    = 1'b1;
          occupied_next[addr] = 1'b0;
        end
      end
      tsa_pkg::ACT_REMOVE: begin
        if (!present) begin
          rsp.status = tsa_pkg::ST_NOT_FOUND;
        end else if (occupied[addr]) begin
          rsp.status = tsa_pkg::ST_OCCUPIED;
        end else begin
          valid_next[addr] = 1'b0;
        end
      end
      tsa_pkg::ACT_ALLOC: begin
        if (cls_ok && found) begin
          rsp.granted_slot    = tsa_pkg::INDEX_W'(gidx);
          occupied_next[gidx] = 1'b1;
        end else begin
          rsp.status = tsa_pkg::ST_NONE_FREE;
        end
      end
      tsa_pkg::ACT_RELEASE: begin
        if (!present) begin
          rsp.status = tsa_pkg::ST_NOT_FOUND;
        end else begin
          occupied_next[addr] = 1'b0;
        end
      end
      tsa_pkg::ACT_QUERY: begin
        if (!present) begin
          rsp.status = tsa_pkg::ST_NOT_FOUND;
        end else begin
          rsp.zone_out = zone_rd;
        end
      end
      tsa_pkg::ACT_CLEAR: begin
        valid_next    = '0;
        occupied_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign zone_we    = commit && do_add;
  assign zone_waddr = addr;
  assign zone_wdata = req.zone_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      occupied <= '0;
    end else if (commit) begin
      valid    <= valid_next;
      occupied <= occupied_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && do_add) begin
      slot_cls[addr] <= req.slot_class;
    end
  end

`ifndef SYNTHESIS
  a_occupied_implies_valid: assert property (@(posedge clk) disable iff (rst)
    (occupied & ~valid) == '0)
    else $error("A slot is marked occupied but not valid.");

  a_grant_marks_occupied: assert property (@(posedge clk) disable iff (rst)
    commit && (req.action == tsa_pkg::ACT_ALLOC) && (rsp.status == tsa_pkg::ST_OK)
    |=> occupied[$past(gidx)])
    else $error("A granted slot was not marked occupied.");

  a_grant_only_on_alloc: assert property (@(posedge clk) disable iff (rst)
    (rsp.granted_slot != '0) |-> (req.action == tsa_pkg::ACT_ALLOC) &&
    (rsp.status == tsa_pkg::ST_OK))
    else $error("A nonzero granted slot appeared outside a successful allocate.");
`endif

endmodule

/* design/typed_slot_allocator_top.sv */
// Typed slot allocator top level: an input register, the slot table and zone memory,
// and a result register. A result trails its request through both registers. One request
// is taken per cycle unless stalled; the combinational priority search over the free masks
// and the registered zone memory read set that rate. Synchronous reset empties both
// registers and clears every valid and occupied mark; class and zone storage is not reset.
// Depends on tsa_pkg, tsa_req_if, tsa_rsp_if, tsa_zone_ram and tsa_slot_table.
module typed_slot_allocator_top #(
  parameter int NUM_SLOTS   = 64,
  parameter int NUM_CLASSES = 4,
  parameter int NUM_ZONES   = 16
) (
  input  logic      clk,
  input  logic      rst,
  tsa_req_if.sink   req,
  tsa_rsp_if.source rsp
);

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic                        s1_vld;
  tsa_pkg::req_t               s1_req;
  logic                        out_vld;
  tsa_pkg::rsp_t               out_rsp;
  tsa_pkg::rsp_t               table_rsp;
  logic                        s1_move;
  logic                        accept;
  logic                        zone_we;
  logic [AW-1:0]               zone_waddr;
  logic [tsa_pkg::ZONE_W-1:0]  zone_wdata;
  logic [tsa_pkg::ZONE_W-1:0]  zone_rd;

  assign s1_move   = s1_vld && (!out_vld || rsp.ready);
  assign req.ready = !s1_vld || s1_move;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld <= 1'b1;
      end else if (s1_move) begin
        s1_vld <= 1'b0;
      end
      if (s1_move) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req.action     <= req.action;
      s1_req.slot_index <= req.slot_index;
      s1_req.slot_class <= req.slot_class;
      s1_req.zone_code  <= req.zone_code;
    end
    if (s1_move) begin
      out_rsp <= table_rsp;
    end
  end

  tsa_zone_ram #(
    .DEPTH (NUM_SLOTS),
    .AW    (AW)
  ) u_zone_ram (
    .clk   (clk),
    .we    (zone_we),
    .waddr (zone_waddr),
    .wdata (zone_wdata),
    .re    (accept),
    .raddr (AW'(req.slot_index)),
    .rdata (zone_rd)
  );

  tsa_slot_table #(
    .NUM_SLOTS   (NUM_SLOTS),
    .NUM_CLASSES (NUM_CLASSES),
    .NUM_ZONES   (NUM_ZONES),
    .AW          (AW)
  ) u_slot_table (
    .clk        (clk),
    .rst        (rst),
    .commit     (s1_move),
    .req        (s1_req),
    .zone_rd    (zone_rd),
    .rsp        (table_rsp),
    .zone_we    (zone_we),
    .zone_waddr (zone_waddr),
    .zone_wdata (zone_wdata)
  );

  assign rsp.valid        = out_vld;
  assign rsp.status       = out_rsp.status;
  assign rsp.granted_slot = out_rsp.granted_slot;
  assign rsp.zone_out     = out_rsp.zone_out;

`ifndef SYNTHESIS
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_vld)
    else $error("An accepted request did not reach the input register.");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_vld && !s1_move |=> s1_vld && (s1_req == $past(s1_req)))
    else $error("A stalled request was lost or changed.");

  a_ready_low_only_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> s1_vld && out_vld && !rsp.ready)
    else $error("Request ready dropped while the pipeline had room.");

  a_move_loads_result: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_vld)
    else $error("A processed request produced no result.");
`endif

endmodule
